// File: rtl/sts_pkg.sv
// types and constants shared by the sorted table search block
// item and result payloads, command codes, sequencer states; no dependencies
package sts_pkg;

	localparam int VALUE_W = 32;
	localparam int POS_W   = 10;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic                      cmd;
		logic signed [VALUE_W-1:0] value;
		logic                      restart;
	} item_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP
	} state_t;

endpackage

// File: rtl/sts_mem.sv
// table storage: one write port, one read port with registered data
// generic, no package dependency
module sts_mem #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/sorted_table_binary_search.sv
// sorted table binary search: load items append words (restart overwrites from word 0), query items search the table
// load item: no result; busy stays low
// query item: each probe is a memory read state, then a compare state; a hit ends the
//   search, and a further read state ends it without a match when the bounds cross
// the single memory read port and the shared compare set the probe rate; results cannot stall
// reset empties the table; stored words are unspecified until loaded again
module sorted_table_binary_search #(
	parameter int CAPACITY = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  sts_pkg::item_t   item,
	output logic            done,
	output sts_pkg::result_t result
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	sts_pkg::state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic signed [sts_pkg::VALUE_W-1:0] e0_q, e1_q, key_q;
	logic [CW-1:0] lo_q, hi_q;  // hi_q is one past the upper bound
	logic [AW-1:0] mid_q;
	logic          done_q;
	sts_pkg::result_t result_q;

	logic          accept;
	logic          load_acc, query_acc;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          rd_en;
	logic [CW-1:0] span, mid_w;
	logic [AW-1:0] mid;
	logic          crossed;
	logic          descending;
	logic [sts_pkg::VALUE_W-1:0] rd_data;
	logic signed [sts_pkg::VALUE_W-1:0] probe;
	logic          hit, go_low;

	assign accept    = start && !busy;
	assign load_acc  = accept && (item.cmd == sts_pkg::CMD_LOAD);
	assign query_acc = accept && (item.cmd == sts_pkg::CMD_QUERY);

	// a load on a full table without restart is dropped
	assign wr_en   = load_acc && (item.restart || (count_q < CW'(CAPACITY)));
	assign wr_addr = item.restart ? '0 : count_q[AW-1:0];

	assign descending = (count_q >= CW'(2)) && (e0_q > e1_q);

	// mid = lo + (hi - lo) / 2 with hi = hi_q - 1
	assign crossed = !(lo_q < hi_q);
	assign span    = hi_q - CW'(1) - lo_q;
	assign mid_w   = lo_q + (span >> 1);
	assign mid     = mid_w[AW-1:0];

	assign probe  = $signed(rd_data);
	assign hit    = (probe == key_q);
	assign go_low = (probe > key_q) != descending;

	sts_mem #(
		.DEPTH(CAPACITY),
		.WIDTH(sts_pkg::VALUE_W)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(item.value),
		.rd_en  (rd_en),
		.rd_addr(mid),
		.rd_data(rd_data)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sts_pkg::ST_IDLE: begin
				if (query_acc) begin
					state_d = sts_pkg::ST_READ;
				end
			end
			sts_pkg::ST_READ: begin
				state_d = crossed ? sts_pkg::ST_IDLE : sts_pkg::ST_CMP;
			end
			sts_pkg::ST_CMP: begin
				state_d = hit ? sts_pkg::ST_IDLE : sts_pkg::ST_READ;
			end
			default: state_d = sts_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy  = (state_q != sts_pkg::ST_IDLE);
		rd_en = (state_q == sts_pkg::ST_READ) && !crossed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sts_pkg::ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ((state_q == sts_pkg::ST_READ) && crossed) ||
				((state_q == sts_pkg::ST_CMP) && hit);
			if (wr_en) begin
				count_q <= (item.restart ? '0 : count_q) + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == '0)) begin
			e0_q <= item.value;
		end
		if (wr_en && (wr_addr == AW'(1))) begin
			e1_q <= item.value;
		end
		if (query_acc) begin
			key_q <= item.value;
			lo_q  <= '0;
			hi_q  <= count_q;
		end
		if (rd_en) begin
			mid_q <= mid;
		end
		if (state_q == sts_pkg::ST_READ && crossed) begin
			result_q.found    <= 1'b0;
			result_q.position <= '0;
		end
		if (state_q == sts_pkg::ST_CMP) begin
			if (hit) begin
				result_q.found    <= 1'b1;
				result_q.position <= sts_pkg::POS_W'(mid_q);
			end else if (go_low) begin
				hi_q <= CW'(mid_q);
			end else begin
				lo_q <= CW'(mid_q) + CW'(1);
			end
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
